>>> hdl/bpsa_pkg.sv
`default_nettype none
package bpsa_pkg;

	localparam int MAX_ORBITALS = 64;
	localparam int PHASE_BITS = 12;
	localparam int ELEMS = MAX_ORBITALS * MAX_ORBITALS;
	localparam int ELEM_BITS = (ELEMS > 1) ? $clog2(ELEMS) : 1;
	localparam int TRIG_ABITS = PHASE_BITS - 2;
	localparam int TRIG_DEPTH = 1 << TRIG_ABITS;

	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);
	localparam int ODEPTH = 4;
	localparam int OPTR_BITS = $clog2(ODEPTH);
	localparam int OCNT_BITS = $clog2(ODEPTH + 1);

	localparam int CFG_INDEX_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_X = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_Y = 8'd1;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint ONE_Q30 = 64'sd1 <<< 30;

	typedef struct packed {
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [23:0] hop_value;
		logic signed [19:0] disp_x;
		logic signed [19:0] disp_y;
		logic               first_slice;
		logic               last_slice;
	} item_t;

	typedef struct packed {
		logic [5:0]         out_row;
		logic [5:0]         out_col;
		logic signed [31:0] sum_real;
		logic signed [31:0] sum_imag;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [PHASE_BITS-1:0] phase_idx;
		logic signed [23:0]    hop;
		logic [ELEM_BITS-1:0]  elem;
		logic [5:0]            row;
		logic [5:0]            col;
		logic                  first;
		logic                  last;
	} work_t;

	typedef struct packed {
		logic                 empty;
		logic [QCNT_BITS-1:0] count;
	} link_stat_t;

	// Each entry holds cos in the upper half and sin in the lower half, unsigned Q1.30 clamped to [0, 1].
	typedef logic [61:0] trig_rom_t [TRIG_DEPTH];

	function automatic trig_rom_t build_trig_rom();
		trig_rom_t rom;
		longint unsigned r16;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned st;
		longint unsigned ct;
		longint sv;
		longint cv;
		for (int i = 0; i < TRIG_DEPTH; i++) begin
			r16 = 64'(i) << (16 - PHASE_BITS);
			x = (r16 * TWO_PI_Q30) >> 16;
			x2 = (x * x) >> 30;
			st = x;
			ct = 64'(ONE_Q30);
			sv = longint'(x);
			cv = ONE_Q30;
			for (int n = 1; n <= 8; n++) begin
				st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					sv = sv - longint'(st);
					cv = cv - longint'(ct);
				end else begin
					sv = sv + longint'(st);
					cv = cv + longint'(ct);
				end
			end
			if (cv < 0) cv = 0;
			if (cv > ONE_Q30) cv = ONE_Q30;
			if (sv < 0) sv = 0;
			if (sv > ONE_Q30) sv = ONE_Q30;
			rom[i] = {cv[30:0], sv[30:0]};
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

>>> hdl/bloch_phase_sum_accumulator.sv
// An accepted item that closes an element passes the front register, the link queue, back stages
// s1 and s2 and the result queue. Throughput: one item per cycle unless full; the accumulator
// memory takes one read and one write per cycle, and the two writes still in flight are forwarded past the read.
// Reset clears all queue pointers, pipeline valids and the k-point registers;
// the accumulator memory is not cleared, since a first slice always writes it.
`default_nettype none
module bloch_phase_sum_accumulator (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    push,
	output logic                                   full,
	input  bpsa_pkg::item_t                        item,
	output logic                                   empty,
	input  wire                                    pop,
	output bpsa_pkg::result_t                      result,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire [bpsa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire [15:0]                             cfg_data
);

	logic signed [15:0]   wave_x_q;
	logic signed [15:0]   wave_y_q;
	logic                 link_push;
	bpsa_pkg::work_t      link_wr_item;
	logic                 link_pop;
	bpsa_pkg::work_t      link_head;
	bpsa_pkg::link_stat_t link_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_x_q <= '0;
			wave_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bpsa_pkg::REG_WAVE_X: wave_x_q <= cfg_data;
				bpsa_pkg::REG_WAVE_Y: wave_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bpsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.wave_x    (wave_x_q),
		.wave_y    (wave_y_q),
		.link_stat (link_stat),
		.link_push (link_push),
		.link_item (link_wr_item)
	);

	bpsa_link u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (link_push),
		.wr_item (link_wr_item),
		.rd_en   (link_pop),
		.rd_item (link_head),
		.stat    (link_stat)
	);

	bpsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.link_stat (link_stat),
		.head      (link_head),
		.link_pop  (link_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		link_pop |-> !link_stat.empty)
		else $error("link queue popped while empty");

	a_link_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(link_stat.count) <= bpsa_pkg::QDEPTH)
		else $error("link queue overflow");

	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> 32'(link_stat.count) >= bpsa_pkg::QDEPTH - 1)
		else $error("full raised with room in the link queue");

	a_no_push_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(link_push && !link_pop) |-> 32'(link_stat.count) < bpsa_pkg::QDEPTH)
		else $error("link write into a full queue");

endmodule
`default_nettype wire

>>> hdl/bpsa_front.sv
`default_nettype none
module bpsa_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  bpsa_pkg::item_t      item,
	input  wire signed [15:0]    wave_x,
	input  wire signed [15:0]    wave_y,
	input  bpsa_pkg::link_stat_t link_stat,
	output logic                 link_push,
	output bpsa_pkg::work_t      link_item
);

	logic                  accept;
	logic                  in_range;
	logic                  valid_s1;
	logic signed [35:0]    prod_x_s1;
	logic signed [35:0]    prod_y_s1;
	bpsa_pkg::item_t       item_s1;
	logic [23:0]           phase_lo;
	logic [23:0]           phase_rnd;

	// Room is reserved in the link queue for the item held in the stage register.
	assign full = (32'(link_stat.count) + 32'(valid_s1)) >= bpsa_pkg::QDEPTH;
	assign accept = push && !full;
	assign in_range = (32'(item.row_index) < bpsa_pkg::MAX_ORBITALS) &&
		(32'(item.col_index) < bpsa_pkg::MAX_ORBITALS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= item.disp_x * wave_x;
			prod_y_s1 <= item.disp_y * wave_y;
			item_s1 <= item;
		end
	end

	// Only the fractional turn matters, so the sum is kept to 24 bits.
	assign phase_lo = prod_x_s1[23:0] + prod_y_s1[23:0];
	assign phase_rnd = phase_lo + 24'(1 << (23 - bpsa_pkg::PHASE_BITS));

	assign link_push = valid_s1;
	always_comb begin
		link_item.phase_idx = phase_rnd[23 -: bpsa_pkg::PHASE_BITS];
		link_item.hop = item_s1.hop_value;
		link_item.elem = bpsa_pkg::ELEM_BITS'(32'(item_s1.row_index) *
			bpsa_pkg::MAX_ORBITALS + 32'(item_s1.col_index));
		link_item.row = item_s1.row_index;
		link_item.col = item_s1.col_index;
		link_item.first = item_s1.first_slice;
		link_item.last = item_s1.last_slice;
	end

endmodule
`default_nettype wire

>>> hdl/bpsa_link.sv
`default_nettype none
module bpsa_link (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  bpsa_pkg::work_t      wr_item,
	input  wire                  rd_en,
	output bpsa_pkg::work_t      rd_item,
	output bpsa_pkg::link_stat_t stat
);

	bpsa_pkg::work_t                    slots [bpsa_pkg::QDEPTH];
	logic [bpsa_pkg::QPTR_BITS-1:0]     wr_ptr_q;
	logic [bpsa_pkg::QPTR_BITS-1:0]     rd_ptr_q;
	logic [bpsa_pkg::QCNT_BITS-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slots[wr_ptr_q] <= wr_item;
	end

	assign rd_item = slots[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule
`default_nettype wire

>>> hdl/bpsa_back.sv
`default_nettype none
module bpsa_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bpsa_pkg::link_stat_t link_stat,
	input  bpsa_pkg::work_t      head,
	output logic                 link_pop,
	output logic                 empty,
	input  wire                  pop,
	output bpsa_pkg::result_t    result
);

	localparam logic [1:0] QUAD_I = 2'd0;
	localparam logic [1:0] QUAD_II = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV = 2'd3;
	localparam bpsa_pkg::trig_rom_t TRIG_ROM = bpsa_pkg::build_trig_rom();
	localparam logic signed [55:0] ROUND_HALF = 56'sd1 <<< 29;

	logic [64:0]              acc_mem [bpsa_pkg::ELEMS];
	logic                     take;
	logic [61:0]              rom_q;
	logic [64:0]              acc_rd_q;
	logic                     valid_s1;
	bpsa_pkg::work_t          item_s1;
	logic signed [31:0]       qc;
	logic signed [31:0]       qs;
	logic signed [31:0]       cos_v;
	logic signed [31:0]       sin_v;
	logic                     valid_s2;
	bpsa_pkg::work_t          item_s2;
	logic signed [55:0]       prod_re_s2;
	logic signed [55:0]       prod_im_s2;
	logic [64:0]              acc_s2;
	logic signed [55:0]       rnd_re;
	logic signed [55:0]       rnd_im;
	logic signed [31:0]       tr_re;
	logic signed [31:0]       tr_im;
	logic [64:0]              old_v;
	logic signed [32:0]       sum_re;
	logic signed [32:0]       sum_im;
	logic                     ovf_re;
	logic                     ovf_im;
	logic signed [31:0]       new_re;
	logic signed [31:0]       new_im;
	logic                     new_mark;
	logic                     w1_valid_q;
	logic [bpsa_pkg::ELEM_BITS-1:0] w1_elem_q;
	logic [64:0]              w1_data_q;
	logic                     w2_valid_q;
	logic [bpsa_pkg::ELEM_BITS-1:0] w2_elem_q;
	logic [64:0]              w2_data_q;
	bpsa_pkg::result_t        ofifo [bpsa_pkg::ODEPTH];
	logic [bpsa_pkg::OPTR_BITS-1:0] owr_q;
	logic [bpsa_pkg::OPTR_BITS-1:0] ord_q;
	logic [bpsa_pkg::OCNT_BITS-1:0] ocount_q;
	logic                     opush;
	logic                     opop;

	// The pipeline never stalls once an item is taken, so the result queue
	// must have room for every item in flight.
	assign take = !link_stat.empty &&
		(32'(ocount_q) + 32'(valid_s1) + 32'(valid_s2)) < bpsa_pkg::ODEPTH;
	assign link_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			w1_valid_q <= 1'b0;
			w2_valid_q <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			w1_valid_q <= valid_s2;
			w2_valid_q <= w1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rom_q <= TRIG_ROM[head.phase_idx[bpsa_pkg::TRIG_ABITS-1:0]];
			acc_rd_q <= acc_mem[head.elem];
			item_s1 <= head;
		end
	end

	assign qc = {1'b0, rom_q[61:31]};
	assign qs = {1'b0, rom_q[30:0]};

	always_comb begin
		case (item_s1.phase_idx[bpsa_pkg::PHASE_BITS-1 -: 2])
			QUAD_I: begin
				cos_v = qc;
				sin_v = qs;
			end
			QUAD_II: begin
				cos_v = -qs;
				sin_v = qc;
			end
			QUAD_III: begin
				cos_v = -qc;
				sin_v = -qs;
			end
			QUAD_IV: begin
				cos_v = qs;
				sin_v = -qc;
			end
			default: begin
				cos_v = qc;
				sin_v = qs;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_re_s2 <= item_s1.hop * cos_v;
		prod_im_s2 <= item_s1.hop * sin_v;
		item_s2 <= item_s1;
		acc_s2 <= acc_rd_q;
	end

	assign rnd_re = (prod_re_s2 + ROUND_HALF) >>> 30;
	assign rnd_im = (prod_im_s2 + ROUND_HALF) >>> 30;
	assign tr_re = rnd_re[31:0];
	assign tr_im = rnd_im[31:0];

	// The memory read misses the two most recent writes; take them from the
	// write history instead, the newer one first.
	always_comb begin
		if (w1_valid_q && w1_elem_q == item_s2.elem) old_v = w1_data_q;
		else if (w2_valid_q && w2_elem_q == item_s2.elem) old_v = w2_data_q;
		else old_v = acc_s2;
	end

	assign sum_re = {old_v[63], old_v[63:32]} + {tr_re[31], tr_re};
	assign sum_im = {old_v[31], old_v[31:0]} + {tr_im[31], tr_im};
	assign ovf_re = sum_re[32] != sum_re[31];
	assign ovf_im = sum_im[32] != sum_im[31];

	always_comb begin
		if (item_s2.first) begin
			new_re = tr_re;
			new_im = tr_im;
			new_mark = 1'b0;
		end else begin
			new_re = ovf_re ? (sum_re[32] ? 32'sh80000000 : 32'sh7fffffff) : sum_re[31:0];
			new_im = ovf_im ? (sum_im[32] ? 32'sh80000000 : 32'sh7fffffff) : sum_im[31:0];
			new_mark = old_v[64] || ovf_re || ovf_im;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) acc_mem[item_s2.elem] <= {new_mark, new_re, new_im};
		w1_elem_q <= item_s2.elem;
		w1_data_q <= {new_mark, new_re, new_im};
		w2_elem_q <= w1_elem_q;
		w2_data_q <= w1_data_q;
	end

	assign opush = valid_s2 && item_s2.last;
	assign opop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			ocount_q <= '0;
		end else begin
			if (opush) owr_q <= owr_q + 1'b1;
			if (opop) ord_q <= ord_q + 1'b1;
			if (opush && !opop) ocount_q <= ocount_q + 1'b1;
			else if (opop && !opush) ocount_q <= ocount_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo[owr_q].out_row <= item_s2.row;
			ofifo[owr_q].out_col <= item_s2.col;
			ofifo[owr_q].sum_real <= new_re;
			ofifo[owr_q].sum_imag <= new_im;
			ofifo[owr_q].saturated <= new_mark;
		end
	end

	assign empty = (ocount_q == '0);
	assign result = ofifo[ord_q];

endmodule
`default_nettype wire
